// File: design/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Operation codes and controller command/status types for the reservation table.
// ----------------------------------------------------------------------------
package srt_pkg;
    localparam logic [2:0] K_RES_NODE = 3'd0;
    localparam logic [2:0] K_RES_LINK = 3'd1;
    localparam logic [2:0] K_QRY_NODE = 3'd2;
    localparam logic [2:0] K_QRY_LINK = 3'd3;
    localparam logic [2:0] K_CLEAR    = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture request fields
        logic rd;        // issue read at current slot address
        logic chk;       // evaluate read data
        logic wr;        // write tag at current slot
        logic step;      // advance slot counter
        logic rewind;    // restart slot counter at range start
        logic clr_init;  // start clearing sweep
        logic done;      // emit result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic last;      // slot counter at range end
        logic conflict;  // a read slot is held by another vehicle
        logic trivial;   // answer known without table access
        logic clr_last;  // sweep at its final entry
    } t_sts;
endpackage

// File: design/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer: walks reads, optional writes, and the clearing sweep.
// ----------------------------------------------------------------------------
module srt_ctrl
    import srt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [2:0] i_kind,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (i_go) r_kind <= i_kind;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.load = i_go;
        case (r_state)
            S_IDLE: if (i_go) n_state = S_DEC;
            S_DEC: begin
                if (r_kind == K_CLEAR) begin
                    o_cmd.clr_init = 1'b1;
                    n_state = S_CLR;
                end else if (i_sts.trivial) begin
                    n_state = S_DONE;
                end else if (r_kind == K_RES_LINK) begin
                    n_state = S_WR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.last) begin
                    if (r_kind == K_RES_NODE) begin
                        o_cmd.rewind = 1'b1;
                        n_state = S_WR;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_RD;
                end
            end
            S_WR: begin
                // A node reservation with any conflict writes nothing.
                if (i_sts.conflict) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.wr = 1'b1;
                    o_cmd.step = !i_sts.last;
                    if (i_sts.last) n_state = S_DONE;
                end
            end
            S_CLR: begin
                if (i_sts.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: design/srt_dp.sv
// ----------------------------------------------------------------------------
// srt_dp
// Datapath: request registers, slot counter, owner memories, sweep counter.
// Memories have no reset; a clearing sweep after reset zeroes them. Each
// memory spans its whole address space, node and slot codes rounded up to
// powers of two, and the sweep covers all of it.
// ----------------------------------------------------------------------------
module srt_dp
    import srt_pkg::*;
#(
    parameter int NUM_NODES    = 16,
    parameter int NUM_SLOTS    = 64,
    parameter int NUM_VEHICLES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [2:0] i_kind,
    input  logic [3:0] i_node_a,
    input  logic [3:0] i_node_b,
    input  logic [5:0] i_start_slot,
    input  logic [5:0] i_end_slot,
    input  logic [3:0] i_vehicle,
    input  logic [5:0] i_current_slot,
    output t_sts       o_sts,
    output logic       o_init_done,
    output logic       o_granted
);
    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NW  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int TW  = $clog2(NUM_VEHICLES + 1);
    localparam int NA  = NW + SW;
    localparam int LA  = 2 * NW + SW;
    localparam int ND  = 1 << NA;
    localparam int LD  = 1 << LA;
    localparam logic [LA:0]   LD_M1     = (LA+1)'(LD - 1);

    logic [TW-1:0] node_mem [ND];
    logic [TW-1:0] link_mem [LD];

    logic [2:0]    r_kind;
    logic [NW-1:0] r_na, r_lo, r_hi;
    logic [SW-1:0] r_s, r_e, r_cur, r_slot;
    logic [TW-1:0] r_tag;
    logic          r_triv, r_ok, r_cur_end;
    logic          r_conf, r_init, r_clr_act, r_granted;
    logic [LA:0]   r_cnt;
    logic [TW-1:0] r_nrd, r_lrd;
    logic [TW-1:0] r_nsw, r_lsw;
    logic          r_swv;
    logic [LA:0]   r_swa;

    // Field decode at load.
    logic [7:0]  veh_mod;
    logic [7:0]  veh_tab [16];
    logic        a_ok, b_ok, empty;
    logic [10:0] e_cut;
    assign a_ok  = 32'(i_node_a) < NUM_NODES;
    assign b_ok  = 32'(i_node_b) < NUM_NODES;
    assign e_cut = (32'(i_end_slot) > NUM_SLOTS - 1) ? 11'(NUM_SLOTS - 1) : 11'(i_end_slot);
    assign empty = 11'(i_start_slot) > e_cut;

    // Vehicle numbers wrap at NUM_VEHICLES; the table is fixed at elaboration.
    for (genvar v = 0; v < 16; v++) begin : g_veh
        assign veh_tab[v] = 8'(v % NUM_VEHICLES);
    end
    assign veh_mod = veh_tab[i_vehicle];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_na    <= NW'(i_node_a);
            r_lo    <= NW'((i_node_a < i_node_b) ? i_node_a : i_node_b);
            r_hi    <= NW'((i_node_a < i_node_b) ? i_node_b : i_node_a);
            r_s     <= SW'(i_start_slot);
            r_e     <= SW'(e_cut);
            r_cur   <= SW'(i_current_slot);
            r_cur_end <= 32'(i_current_slot) >= NUM_SLOTS - 1;
            r_tag   <= TW'(veh_mod + 8'd1);
            r_slot  <= SW'(i_start_slot);
            r_conf  <= 1'b0;
            case (i_kind)
                K_RES_NODE, K_QRY_NODE: begin
                    r_ok <= a_ok; r_triv <= !a_ok || empty;
                end
                K_RES_LINK, K_QRY_LINK: begin
                    r_ok <= a_ok && b_ok; r_triv <= !(a_ok && b_ok) || empty;
                end
                K_CLEAR: begin
                    r_ok <= 1'b1; r_triv <= 1'b0;
                end
                default: begin
                    r_ok <= 1'b0; r_triv <= 1'b1;
                end
            endcase
        end else begin
            if (i_cmd.rewind) r_slot <= r_s;
            else if (i_cmd.step) r_slot <= r_slot + SW'(1);
            if (i_cmd.chk) begin
                if (r_kind == K_QRY_LINK) begin
                    if (r_lrd != '0 && r_lrd != r_tag) r_conf <= 1'b1;
                end else if (r_nrd != '0 && r_nrd != r_tag) begin
                    r_conf <= 1'b1;
                end
            end
        end
    end

    // Memory read ports, registered.
    logic [NA-1:0] n_addr;
    logic [LA-1:0] l_addr;
    assign n_addr = {r_na, r_slot};
    assign l_addr = {r_lo, r_hi, r_slot};
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_nrd <= node_mem[n_addr];
            r_lrd <= link_mem[l_addr];
        end
    end

    // Clearing sweep over both tables; after reset it zeroes everything.
    logic [SW-1:0] sw_slot;
    logic          sw_hit_l, sw_hit_n, sw_in_n;
    assign sw_slot  = r_swa[SW-1:0];
    assign sw_in_n  = r_swa[LA-1:NA] == '0 && !r_swa[LA];
    assign sw_hit_l = !r_init || (sw_slot > r_cur && r_lsw == r_tag);
    assign sw_hit_n = !r_init || (sw_slot > r_cur && r_nsw == r_tag);

    always_ff @(posedge i_clk) begin
        // Stage 1 read for sweep, stage 2 conditional clear.
        r_lsw <= link_mem[r_cnt[LA-1:0]];
        r_nsw <= node_mem[r_cnt[NA-1:0]];
        r_swa <= r_cnt;
        if (!i_rst_n) begin
            r_init    <= 1'b0;
            r_clr_act <= 1'b1;
            r_cnt     <= '0;
            r_swv     <= 1'b0;
        end else begin
            r_swv <= r_clr_act;
            if (i_cmd.clr_init) begin
                r_clr_act <= !r_cur_end;
                r_cnt     <= '0;
            end else if (r_clr_act) begin
                if (r_cnt == LD_M1) r_clr_act <= 1'b0;
                r_cnt <= r_cnt + (LA+1)'(1);
            end
            if (r_swv && !r_clr_act && !i_cmd.clr_init) r_init <= 1'b1;
        end
    end

    // Write port of each memory: sweep or reservation write.
    always_ff @(posedge i_clk) begin
        if (r_swv && sw_hit_l) link_mem[r_swa[LA-1:0]] <= '0;
        else if (i_cmd.wr && r_kind == K_RES_LINK) link_mem[l_addr] <= r_tag;
        if (r_swv && sw_in_n && sw_hit_n) node_mem[r_swa[NA-1:0]] <= '0;
        else if (i_cmd.wr && r_kind == K_RES_NODE) node_mem[n_addr] <= r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            case (r_kind)
                K_RES_LINK, K_CLEAR: r_granted <= 1'b1;
                K_RES_NODE, K_QRY_NODE, K_QRY_LINK:
                    r_granted <= r_ok && (r_triv || !r_conf);
                default: r_granted <= 1'b0;
            endcase
        end
    end

    assign o_sts.last     = (r_slot == r_e);
    assign o_sts.conflict = r_conf;
    assign o_sts.trivial  = r_triv;
    assign o_sts.clr_last = !r_clr_act && !r_swv;
    assign o_init_done    = r_init;
    assign o_granted      = r_granted;
endmodule

// File: design/slot_reservation_table.sv
// ----------------------------------------------------------------------------
// slot_reservation_table
// Space-time reservation table for nodes and undirected links.
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// request   i_kind .. i_current_slot                start & !busy
// result    o_granted                               o_done, one cycle
//
// A query over n slots reads and checks each slot in turn; a node
// reservation then writes every slot when granted and none when rejected;
// a link reservation writes without reading, and a request answered without
// the tables skips them. Clear sweeps the link address space of L entries
// (each dimension rounded up to a power of two) unless the current slot is
// the last one; after reset the same sweep holds busy. The receiver cannot stall.
// ----------------------------------------------------------------------------
module slot_reservation_table
    import srt_pkg::*;
#(
    parameter int NUM_NODES    = 16,
    parameter int NUM_SLOTS    = 64,
    parameter int NUM_VEHICLES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_kind,
    input  logic [3:0] i_node_a,
    input  logic [3:0] i_node_b,
    input  logic [5:0] i_start_slot,
    input  logic [5:0] i_end_slot,
    input  logic [3:0] i_vehicle,
    input  logic [5:0] i_current_slot,
    output logic       o_done,
    output logic       o_granted
);
    t_cmd cmd;
    t_sts sts;
    logic ctl_busy, init_done, go, r_done;

    assign busy = ctl_busy || !init_done;
    assign go   = start && !busy;

    srt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_kind(i_kind),
        .i_sts(sts), .o_cmd(cmd), .o_busy(ctl_busy)
    );

    srt_dp #(
        .NUM_NODES(NUM_NODES), .NUM_SLOTS(NUM_SLOTS), .NUM_VEHICLES(NUM_VEHICLES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_kind(i_kind),
        .i_node_a(i_node_a), .i_node_b(i_node_b), .i_start_slot(i_start_slot),
        .i_end_slot(i_end_slot), .i_vehicle(i_vehicle),
        .i_current_slot(i_current_slot), .o_sts(sts), .o_init_done(init_done),
        .o_granted(o_granted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= cmd.done;
    end
    assign o_done = r_done;
endmodule

// File: design/srt_checker.sv
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks of the command handshake of the reservation table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module srt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);
    // A transaction always keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_go, i_clk, i_rst_n, start && !busy, busy)
    // A result ends the transaction, so the block is idle while it is shown.
    `ASSERT_IMPL(a_idle_at_done, i_clk, i_rst_n, o_done, !busy)
    // Results never come back to back.
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
endmodule

bind slot_reservation_table srt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives reservation, query and clear transactions into the slot reservation
// table and checks the grant of each result against an ownership table model.
// ----------------------------------------------------------------------------
module testbench;
    import srt_pkg::*;

    localparam int N_NODES  = 16;
    localparam int N_SLOTS  = 64;
    localparam int CYC_MAX  = 20000000;
    localparam int DRAIN    = 200;

    typedef struct {
        logic [2:0] kind;
        logic [3:0] node_a;
        logic [3:0] node_b;
        logic [5:0] start_slot;
        logic [5:0] end_slot;
        logic [3:0] vehicle;
        logic [5:0] current_slot;
    } t_request;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_kind;
    logic [3:0] i_node_a;
    logic [3:0] i_node_b;
    logic [5:0] i_start_slot;
    logic [5:0] i_end_slot;
    logic [3:0] i_vehicle;
    logic [5:0] i_current_slot;
    logic       o_done;
    logic       o_granted;

    // Owner tags: 0 free, else vehicle + 1.
    logic [4:0] node_tag [N_NODES][N_SLOTS];
    logic [4:0] link_tag [N_NODES][N_NODES][N_SLOTS];

    t_request   pending_q [$];
    logic       grant_q [$];
    int         accepted_cnt;
    int         issued_cnt;
    int         gap_left;
    int         error_cnt;
    int         cycle_cnt;

    slot_reservation_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_start_slot   (i_start_slot),
        .i_end_slot     (i_end_slot),
        .i_vehicle      (i_vehicle),
        .i_current_slot (i_current_slot),
        .o_done         (o_done),
        .o_granted      (o_granted)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_cnt++;
    endtask

    // Appends a request at the tail of the pending queue.
    function automatic void queue_request(input t_request r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    // Applies one transaction to the ownership tables and returns the grant.
    function automatic logic apply_request(input t_request r);
        int   lo, hi, last_slot;
        logic [4:0] tag;
        logic ok;
        lo = int'((r.node_a < r.node_b) ? r.node_a : r.node_b);
        hi = int'((r.node_a < r.node_b) ? r.node_b : r.node_a);
        last_slot = int'(r.end_slot);
        tag = 5'(r.vehicle) + 5'd1;
        ok = 1'b1;
        case (r.kind)
            K_RES_NODE, K_QRY_NODE: begin
                for (int s = int'(r.start_slot); s <= last_slot; s++) begin
                    if (node_tag[r.node_a][s] != 0 && node_tag[r.node_a][s] != tag) ok = 1'b0;
                end
                if (ok && r.kind == K_RES_NODE) begin
                    for (int s = int'(r.start_slot); s <= last_slot; s++)
                        node_tag[r.node_a][s] = tag;
                end
                return ok;
            end
            K_RES_LINK: begin
                for (int s = int'(r.start_slot); s <= last_slot; s++) link_tag[lo][hi][s] = tag;
                return 1'b1;
            end
            K_QRY_LINK: begin
                for (int s = int'(r.start_slot); s <= last_slot; s++) begin
                    if (link_tag[lo][hi][s] != 0 && link_tag[lo][hi][s] != tag) ok = 1'b0;
                end
                return ok;
            end
            K_CLEAR: begin
                for (int s = int'(r.current_slot) + 1; s < N_SLOTS; s++) begin
                    for (int a = 0; a < N_NODES; a++) begin
                        if (node_tag[a][s] == tag) node_tag[a][s] = 5'd0;
                        for (int b = 0; b < N_NODES; b++) begin
                            if (link_tag[a][b][s] == tag) link_tag[a][b][s] = 5'd0;
                        end
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_request make_request(input logic [2:0] k, input int a, input int b,
                                              input int s, input int e, input int v,
                                              input int c);
        t_request r;
        r.kind = k;
        r.node_a = 4'(a);
        r.node_b = 4'(b);
        r.start_slot = 6'(s);
        r.end_slot = 6'(e);
        r.vehicle = 4'(v);
        r.current_slot = 6'(c);
        return r;
    endfunction

    // Random transaction: mostly a few nodes and vehicles so that they collide.
    function automatic t_request random_request();
        t_request r;
        int pick, s;
        pick = $urandom_range(0, 99);
        if (pick < 30)      r.kind = K_RES_NODE;
        else if (pick < 55) r.kind = K_RES_LINK;
        else if (pick < 75) r.kind = K_QRY_NODE;
        else if (pick < 94) r.kind = K_QRY_LINK;
        else if (pick < 97) r.kind = K_CLEAR;
        else                r.kind = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 4) == 0) begin
            r.node_a = 4'($urandom);
            r.node_b = 4'($urandom);
            r.vehicle = 4'($urandom);
        end else begin
            r.node_a = 4'($urandom_range(0, 3));
            r.node_b = 4'($urandom_range(0, 3));
            r.vehicle = 4'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 9) == 0) begin
            r.start_slot = 6'($urandom);
            r.end_slot = 6'($urandom);
        end else begin
            s = $urandom_range(0, 63);
            r.start_slot = 6'(s);
            r.end_slot = 6'((s + $urandom_range(0, 7) > 63) ? 63 : s + $urandom_range(0, 7));
        end
        r.current_slot = 6'($urandom);
        return r;
    endfunction

    // Driver: a new request appears on the falling edge after the previous
    // transaction was taken, possibly after a random idle burst.
    always @(negedge i_clk) begin
        t_request r;
        logic     nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && accepted_cnt != issued_cnt)) begin
            nxt = 1'b0;
            if (start && pending_q.size() > 60 && $urandom_range(0, 2) == 0)
                gap_left = $urandom_range(1, 10);
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                r = pending_q.pop_front();
                i_kind <= r.kind;
                i_node_a <= r.node_a;
                i_node_b <= r.node_b;
                i_start_slot <= r.start_slot;
                i_end_slot <= r.end_slot;
                i_vehicle <= r.vehicle;
                i_current_slot <= r.current_slot;
                issued_cnt++;
                nxt = 1'b1;
            end
            start <= nxt;
        end
    end

    // Monitor: predicts at acceptance, checks at the done strobe.
    always @(posedge i_clk) begin
        t_request r;
        logic     exp_grant;
        cycle_cnt++;
        if (i_rst_n && start && !busy) begin
            r = make_request(i_kind, int'(i_node_a), int'(i_node_b), int'(i_start_slot),
                             int'(i_end_slot), int'(i_vehicle), int'(i_current_slot));
            grant_q.insert(grant_q.size(), apply_request(r));
            accepted_cnt++;
        end
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                exp_grant = grant_q.pop_front();
                if (o_granted !== exp_grant)
                    report_mismatch($sformatf("granted %b, expected %b", o_granted, exp_grant));
            end
        end
        if (cycle_cnt > CYC_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        start = 1'b0;
        i_kind = K_RES_NODE;
        i_node_a = '0;
        i_node_b = '0;
        i_start_slot = '0;
        i_end_slot = '0;
        i_vehicle = '0;
        i_current_slot = '0;
        gap_left = 0;
        error_cnt = 0;
        cycle_cnt = 0;
        accepted_cnt = 0;
        issued_cnt = 0;
        foreach (node_tag[a, s]) node_tag[a][s] = 5'd0;
        foreach (link_tag[a, b, s]) link_tag[a][b][s] = 5'd0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Directed: full range, conflicts, empty ranges, link key
        // symmetry, same-end links, clears at the last slots, unknown kinds.
        queue_request(make_request(K_RES_NODE, 15, 0, 0, 63, 15, 0));
        queue_request(make_request(K_RES_NODE, 15, 0, 10, 10, 0, 0));
        queue_request(make_request(K_QRY_NODE, 15, 0, 63, 63, 15, 0));
        queue_request(make_request(K_QRY_NODE, 15, 0, 20, 5, 3, 0));
        queue_request(make_request(K_RES_NODE, 0, 9, 40, 2, 1, 0));
        queue_request(make_request(K_RES_LINK, 15, 0, 0, 63, 7, 0));
        queue_request(make_request(K_QRY_LINK, 0, 15, 5, 9, 8, 0));
        queue_request(make_request(K_QRY_LINK, 0, 15, 5, 9, 7, 0));
        queue_request(make_request(K_RES_LINK, 5, 5, 3, 6, 2, 0));
        queue_request(make_request(K_QRY_LINK, 5, 5, 0, 63, 1, 0));
        queue_request(make_request(K_RES_LINK, 3, 4, 9, 1, 4, 0));
        queue_request(make_request(K_QRY_LINK, 3, 4, 9, 1, 4, 0));
        queue_request(make_request(K_CLEAR, 0, 0, 0, 0, 15, 63));
        queue_request(make_request(K_CLEAR, 0, 0, 0, 0, 7, 62));
        queue_request(make_request(K_QRY_LINK, 15, 0, 63, 63, 0, 0));
        queue_request(make_request(K_CLEAR, 0, 0, 0, 0, 15, 30));
        queue_request(make_request(K_QRY_NODE, 15, 0, 0, 63, 0, 0));
        queue_request(make_request(K_QRY_NODE, 15, 0, 0, 30, 0, 0));
        queue_request(make_request(3'd5, 15, 15, 63, 63, 15, 63));
        queue_request(make_request(3'd6, 0, 0, 0, 0, 0, 0));
        queue_request(make_request(3'd7, 10, 5, 1, 2, 9, 4));
        repeat (450) queue_request(random_request());

        wait (pending_q.size() == 0 && accepted_cnt == issued_cnt && grant_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
